// ===== hdl/cqs_pkg.sv =====
`timescale 1ns / 1ps
// cqs_pkg: operation and status codes for the circular queue with search
// no dependencies; used by cqs_mem, cqs_ctrl and the top level

package cqs_pkg;

	// operation codes carried on mode
	localparam logic [1:0] MODE_ENQ  = 2'd0;
	localparam logic [1:0] MODE_DEQ  = 2'd1;
	localparam logic [1:0] MODE_SRCH = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [1:0] ST_NOTFOUND  = 2'd3;

	// fixed field widths
	localparam int WORD_W = 32;
	localparam int POS_W  = 3;

endpackage

// ===== hdl/cqs_mem.sv =====
`timescale 1ns / 1ps
// cqs_mem: slot storage, one write port and one read port, registered read data
// depends on cqs_pkg for the word width

module cqs_mem #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [cqs_pkg::WORD_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [cqs_pkg::WORD_W-1:0] rdata
);

	logic [cqs_pkg::WORD_W-1:0] mem_q [DEPTH];
	logic [cqs_pkg::WORD_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered; rdata holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/cqs_ctrl.sv =====
`timescale 1ns / 1ps
// cqs_ctrl: queue pointers, operation sequencer, search scan and result register
// depends on cqs_pkg; drives the ports of cqs_mem

module cqs_ctrl #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        mode,
	input  logic signed [cqs_pkg::WORD_W-1:0] value_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic signed [cqs_pkg::WORD_W-1:0] value_out,
	output logic [cqs_pkg::POS_W-1:0]         position,
	output logic                              mem_we,
	output logic [AW-1:0]                     mem_waddr,
	output logic [cqs_pkg::WORD_W-1:0]        mem_wdata,
	output logic                              mem_re,
	output logic [AW-1:0]                     mem_raddr,
	input  logic [cqs_pkg::WORD_W-1:0]        mem_rdata,
	output logic                              busy,
	output logic                              empty
);

	localparam int XW = (AW > cqs_pkg::POS_W) ? AW : cqs_pkg::POS_W;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	typedef enum logic [1:0] {S_IDLE, S_DEQ, S_SRCH} state_t;

	state_t                      state_q;
	logic [AW-1:0]               head_q;
	logic [AW-1:0]               tail_q;
	logic                        empty_q;
	logic [AW-1:0]               ptr_q;
	logic [cqs_pkg::WORD_W-1:0]  key_q;
	logic                        ov_q;
	logic [1:0]                  status_q;
	logic [cqs_pkg::WORD_W-1:0]  vout_q;
	logic [cqs_pkg::POS_W-1:0]   pos_q;

	logic [AW-1:0] next_head;
	logic [AW-1:0] next_tail;
	logic [AW-1:0] next_ptr;
	logic [XW-1:0] ptr_ext;
	logic          accept;
	logic          full;
	logic          hit;

	// wrap-around successors
	assign next_head = (head_q == LAST) ? '0 : head_q + 1'b1;
	assign next_tail = (tail_q == LAST) ? '0 : tail_q + 1'b1;
	assign next_ptr  = (ptr_q == LAST) ? '0 : ptr_q + 1'b1;
	assign ptr_ext   = XW'(ptr_q);

	assign full   = !empty_q && (next_tail == head_q);
	assign hit    = (mem_rdata == key_q);
	assign in_ready = (state_q == S_IDLE) && (!ov_q || out_ready);
	assign accept = in_valid && in_ready;

	// memory requests
	assign mem_we    = accept && (mode == cqs_pkg::MODE_ENQ) && !full;
	assign mem_waddr = empty_q ? '0 : next_tail;
	assign mem_wdata = $unsigned(value_in);
	assign mem_re    = (accept && !empty_q &&
	                    (mode == cqs_pkg::MODE_DEQ || mode == cqs_pkg::MODE_SRCH)) ||
	                   (state_q == S_SRCH && !hit && ptr_q != tail_q);
	assign mem_raddr = (state_q == S_SRCH) ? next_ptr : head_q;

	// sequencer, pointers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			empty_q  <= 1'b1;
			ptr_q    <= '0;
			key_q    <= '0;
			ov_q     <= 1'b0;
			status_q <= cqs_pkg::ST_OK;
			vout_q   <= '0;
			pos_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (mode)
							cqs_pkg::MODE_ENQ: begin
								ov_q   <= 1'b1;
								vout_q <= '0;
								pos_q  <= '0;
								if (empty_q) begin
									head_q   <= '0;
									tail_q   <= '0;
									empty_q  <= 1'b0;
									status_q <= cqs_pkg::ST_OK;
								end else if (full) begin
									status_q <= cqs_pkg::ST_OVERFLOW;
								end else begin
									tail_q   <= next_tail;
									status_q <= cqs_pkg::ST_OK;
								end
							end
							cqs_pkg::MODE_DEQ: begin
								if (empty_q) begin
									ov_q     <= 1'b1;
									status_q <= cqs_pkg::ST_UNDERFLOW;
									vout_q   <= '0;
									pos_q    <= '0;
								end else begin
									// previous result leaves as this item enters
									ov_q    <= 1'b0;
									state_q <= S_DEQ;
									if (head_q == tail_q) begin
										empty_q <= 1'b1;
										head_q  <= '0;
										tail_q  <= '0;
									end else begin
										head_q <= next_head;
									end
								end
							end
							cqs_pkg::MODE_SRCH: begin
								if (empty_q) begin
									ov_q     <= 1'b1;
									status_q <= cqs_pkg::ST_UNDERFLOW;
									vout_q   <= '0;
									pos_q    <= '0;
								end else begin
									ov_q    <= 1'b0;
									ptr_q   <= head_q;
									key_q   <= $unsigned(value_in);
									state_q <= S_SRCH;
								end
							end
							default: begin
								// unused code: no change, plain ok result
								ov_q     <= 1'b1;
								status_q <= cqs_pkg::ST_OK;
								vout_q   <= '0;
								pos_q    <= '0;
							end
						endcase
					end else if (ov_q && out_ready) begin
						ov_q <= 1'b0;
					end
				end
				S_DEQ: begin
					// front word arrives from memory
					ov_q     <= 1'b1;
					status_q <= cqs_pkg::ST_OK;
					vout_q   <= mem_rdata;
					pos_q    <= '0;
					state_q  <= S_IDLE;
				end
				S_SRCH: begin
					// compare one slot per cycle, front to rear
					if (hit) begin
						ov_q     <= 1'b1;
						status_q <= cqs_pkg::ST_OK;
						vout_q   <= '0;
						pos_q    <= ptr_ext[cqs_pkg::POS_W-1:0];
						state_q  <= S_IDLE;
					end else if (ptr_q == tail_q) begin
						ov_q     <= 1'b1;
						status_q <= cqs_pkg::ST_NOTFOUND;
						vout_q   <= '0;
						pos_q    <= '0;
						state_q  <= S_IDLE;
					end else begin
						ptr_q <= next_ptr;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = ov_q;
	assign status    = status_q;
	assign value_out = $signed(vout_q);
	assign position  = pos_q;
	assign busy      = (state_q != S_IDLE);
	assign empty     = empty_q;

endmodule

// ===== hdl/circular_queue_with_search_top.sv =====
`timescale 1ns / 1ps
// circular_queue_with_search_top: enqueue/dequeue/search queue over a slot memory
// enqueue and empty-queue or unused operations register their result directly; dequeue
// reads the front slot first; search compares k slots, 1 to DEPTH, before its result
// no item is taken while a dequeue or search is in flight; the search scan reads one slot
// a cycle through the single memory read port; a pending result holds off the next item
// reset: arst_n clears pointers, the empty flag and the result register; no clearing pass

module circular_queue_with_search_top #(
	parameter int DEPTH = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        mode,
	input  logic signed [cqs_pkg::WORD_W-1:0] value_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic signed [cqs_pkg::WORD_W-1:0] value_out,
	output logic [cqs_pkg::POS_W-1:0]         position
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	logic [cqs_pkg::WORD_W-1:0] mem_wdata;
	logic                       mem_re;
	logic [AW-1:0]              mem_raddr;
	logic [cqs_pkg::WORD_W-1:0] mem_rdata;
	logic                       busy;
	logic                       empty;

	// sequencer and pointers
	cqs_ctrl #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.value_in (value_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.value_out(value_out),
		.position (position),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.busy     (busy),
		.empty    (empty)
	);

	// slot storage
	cqs_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// no item taken while a dequeue or search is in flight
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready)
		else $error("item accepted during dequeue or search");

	// enqueue result is ready the cycle after the item
	a_enq_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && mode == cqs_pkg::MODE_ENQ) |=> out_valid)
		else $error("enqueue result missing");

	// dequeue of a nonempty queue delivers after the memory read
	a_deq_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && mode == cqs_pkg::MODE_DEQ && !empty) |-> ##2 out_valid)
		else $error("dequeue result missing");

	// dequeue or search on an empty queue reports underflow at once
	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && empty &&
		 (mode == cqs_pkg::MODE_DEQ || mode == cqs_pkg::MODE_SRCH))
		|=> (out_valid && status == cqs_pkg::ST_UNDERFLOW))
		else $error("underflow not reported");

endmodule
